// ----- hdl/silu_pkg.sv -----
// Shared types and constants for the Q16.16 SiLU activation core.
// Depends on nothing; used by every module in hdl/.
`default_nettype none

package silu_pkg;

   // Width of a Q16.16 beat.
   localparam int DATA_W    = 32;
   // Magnitudes below 16.0 fit in this many bits (16.0 is 2^20 in Q16.16).
   localparam int MAG_W     = 20;
   // Scale of |x| when it forms the base 1 - |x|/1024 in Q32.
   localparam int EXP_SHIFT = 6;
   // Number of repeated squarings of the exponential base.
   localparam int SQUARINGS = 10;
   // Divisor and partial remainder width: 2^32 + e.
   localparam int DIV_W     = DATA_W + 1;
   // Quotient bits; the sigmoid never exceeds 2^16.
   localparam int QUO_W     = 17;
   // Product of magnitude and sigmoid.
   localparam int PROD_W    = MAG_W + QUO_W;

   // Per-beat sideband carried down the pipeline.
   typedef struct packed {
      logic              neg;
      logic              special;
      logic [DATA_W-1:0] special_val;
      logic [MAG_W-1:0]  mag;
   } side_type;

   // State of one restoring-division step.
   typedef struct packed {
      logic [DIV_W-1:0] divisor;
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
   } div_type;

endpackage

`default_nettype wire

// ----- hdl/silu_sq_stage.sv -----
// One pipeline stage of the exponential: squares a Q32 value, keeps the upper half.
// Depends on silu_pkg.
`default_nettype none

module silu_sq_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       prev_valid,
   input  silu_pkg::side_type         prev_side,
   input  logic [silu_pkg::DATA_W-1:0] prev_e,
   output logic                       stage_valid,
   output silu_pkg::side_type         stage_side,
   output logic [silu_pkg::DATA_W-1:0] stage_e
);

   logic [2*silu_pkg::DATA_W-1:0] sq;
   logic                          valid_ff;
   silu_pkg::side_type            side_ff;
   logic [silu_pkg::DATA_W-1:0]   e_ff;
   logic [silu_pkg::DATA_W-1:0]   e_in;

   assign sq   = (2*silu_pkg::DATA_W)'(prev_e) * (2*silu_pkg::DATA_W)'(prev_e);
   assign e_in = sq[2*silu_pkg::DATA_W-1:silu_pkg::DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= prev_side;
         e_ff    <= e_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_side  = side_ff;
   assign stage_e     = e_ff;

endmodule

`default_nettype wire

// ----- hdl/silu_div_stage.sv -----
// One restoring-division step: brings in one numerator bit, produces one quotient bit.
// Depends on silu_pkg.
`default_nettype none

module silu_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               prev_valid,
   input  silu_pkg::side_type prev_side,
   input  silu_pkg::div_type  prev_div,
   output logic               stage_valid,
   output silu_pkg::side_type stage_side,
   output silu_pkg::div_type  stage_div
);

   logic [silu_pkg::DIV_W:0]   r2;
   logic [silu_pkg::DIV_W+1:0] diff;
   logic                       ge;
   logic                       valid_ff;
   silu_pkg::side_type         side_ff;
   silu_pkg::div_type          div_ff;
   silu_pkg::div_type          div_in;

   always_comb begin
      r2   = {prev_div.rem, prev_div.low[silu_pkg::QUO_W-1]};
      diff = {1'b0, r2} - {2'b00, prev_div.divisor};
      ge   = ~diff[silu_pkg::DIV_W+1];
      div_in.divisor = prev_div.divisor;
      div_in.rem     = ge ? diff[silu_pkg::DIV_W-1:0] : r2[silu_pkg::DIV_W-1:0];
      div_in.low     = {prev_div.low[silu_pkg::QUO_W-2:0], 1'b0};
      div_in.quo     = {prev_div.quo[silu_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= prev_side;
         div_ff  <= div_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_side  = side_ff;
   assign stage_div   = div_ff;

   // Partial remainder stays below the divisor after every step.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (div_ff.rem < div_ff.divisor))
      else $error("division remainder not below divisor");

endmodule

`default_nettype wire

// ----- hdl/silu_q16_activation_core.sv -----
// SiLU activation core, signed Q16.16 in and out: value_out = x * sigmoid(x).
// Depends on silu_pkg, silu_sq_stage and silu_div_stage.
`default_nettype none

// The core takes one Q16.16 beat per clock and returns one result per beat, in
// order. It is a fully pipelined datapath of 32 register stages. Two stages form |x|,
// the saturation flags and the exponential base 1 - |x|/1024, ten stages each hold
// one 32x32 squaring multiplier, one stage sets up the division, seventeen stages
// each retire one quotient bit of the sigmoid, one stage multiplies |x| by the sigmoid
// and the last stage applies the sign, floor shift and special cases into the output
// register. Zero gives zero; |x| >= 16.0 gives x for positive and 0 for negative
// inputs. While the output beat waits under rsp_stall, the whole pipeline holds and
// req_stall is raised in the same cycle; otherwise a new beat is taken every clock,
// including the cycle in which the waiting result leaves.

module silu_q16_activation_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [silu_pkg::DATA_W-1:0] req_value_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [silu_pkg::DATA_W-1:0] rsp_value_out
);

   localparam int DW = silu_pkg::DATA_W;
   localparam int MW = silu_pkg::MAG_W;
   localparam int NS = silu_pkg::SQUARINGS;
   localparam int QW = silu_pkg::QUO_W;
   localparam int PW = silu_pkg::PROD_W;

   // Advance every stage unless the output beat is stuck.
   logic advance;
   assign advance   = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~advance;

   // ---------------------------------------------------------------- stage A
   // Take the sign and the magnitude. The most negative input negates to itself,
   // which is already its magnitude as an unsigned value.
   logic          a_valid_ff;
   logic          a_neg_ff, a_neg_in;
   logic [DW-1:0] a_raw_ff;
   logic [DW-1:0] a_abs_ff, a_abs_in;

   assign a_neg_in = req_value_in[DW-1];
   assign a_abs_in = a_neg_in ? (DW'(0) - DW'(req_value_in)) : DW'(req_value_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_neg_ff <= a_neg_in;
         a_raw_ff <= DW'(req_value_in);
         a_abs_ff <= a_abs_in;
      end
   end

   // ---------------------------------------------------------------- stage B
   // Flag zero and saturated inputs, form the base 2^32 - (|x| << 6) in Q32.
   logic               b_valid_ff;
   silu_pkg::side_type b_side_ff, b_side_in;
   logic [DW-1:0]      b_e_ff, b_e_in;
   logic               a_zero;
   logic [DW:0]        base_full;

   always_comb begin
      a_zero                = (a_raw_ff == '0);
      b_side_in.neg         = a_neg_ff;
      b_side_in.special     = a_zero | (a_abs_ff[DW-1:MW] != '0);
      b_side_in.special_val = (a_zero | a_neg_ff) ? '0 : a_raw_ff;
      b_side_in.mag         = a_abs_ff[MW-1:0];
      base_full             = {1'b1, {DW{1'b0}}}
                              - ((DW+1)'(a_abs_ff[MW-1:0]) << silu_pkg::EXP_SHIFT);
      b_e_in                = base_full[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_side_ff <= b_side_in;
         b_e_ff    <= b_e_in;
      end
   end

   // ---------------------------------------------------------------- squarings
   logic               sq_valid [NS+1];
   silu_pkg::side_type sq_side  [NS+1];
   logic [DW-1:0]      sq_e     [NS+1];

   assign sq_valid[0] = b_valid_ff;
   assign sq_side[0]  = b_side_ff;
   assign sq_e[0]     = b_e_ff;

   for (genvar i = 0; i < NS; i++) begin : g_sq
      silu_sq_stage u_sq (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .prev_valid  (sq_valid[i]),
         .prev_side   (sq_side[i]),
         .prev_e      (sq_e[i]),
         .stage_valid (sq_valid[i+1]),
         .stage_side  (sq_side[i+1]),
         .stage_e     (sq_e[i+1])
      );
   end

   // ---------------------------------------------------------------- stage C
   // Set up the sigmoid division by d = 2^32 + e. Numerator is 2^48 for positive x
   // and e << 16 for negative x; seed the remainder with its top bits and keep the
   // lower QUO_W bits to shift in one per step.
   logic               c_valid_ff;
   silu_pkg::side_type c_side_ff;
   silu_pkg::div_type  c_div_ff, c_div_in;
   logic [DW-1:0]      e_fin;

   always_comb begin
      e_fin            = sq_e[NS];
      c_div_in.divisor = {1'b1, e_fin};
      c_div_in.quo     = '0;
      if (sq_side[NS].neg) begin
         c_div_in.rem = {2'b00, e_fin[DW-1:1]};
         c_div_in.low = {e_fin[0], {(QW-1){1'b0}}};
      end else begin
         c_div_in.rem = {1'b0, 1'b1, {(DW-1){1'b0}}};
         c_div_in.low = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= sq_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_side_ff <= sq_side[NS];
         c_div_ff  <= c_div_in;
      end
   end

   // ---------------------------------------------------------------- division
   logic               dv_valid [QW+1];
   silu_pkg::side_type dv_side  [QW+1];
   silu_pkg::div_type  dv_div   [QW+1];

   assign dv_valid[0] = c_valid_ff;
   assign dv_side[0]  = c_side_ff;
   assign dv_div[0]   = c_div_ff;

   for (genvar j = 0; j < QW; j++) begin : g_div
      silu_div_stage u_div (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .prev_valid  (dv_valid[j]),
         .prev_side   (dv_side[j]),
         .prev_div    (dv_div[j]),
         .stage_valid (dv_valid[j+1]),
         .stage_side  (dv_side[j+1]),
         .stage_div   (dv_div[j+1])
      );
   end

   // ---------------------------------------------------------------- stage M
   // Multiply the magnitude by the sigmoid.
   logic               m_valid_ff;
   silu_pkg::side_type m_side_ff;
   logic [PW-1:0]      m_prod_ff, m_prod_in;

   assign m_prod_in = PW'(dv_side[QW].mag) * PW'(dv_div[QW].quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= dv_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_side_ff <= dv_side[QW];
         m_prod_ff <= m_prod_in;
      end
   end

   // ---------------------------------------------------------------- output
   // Negate for negative x, then floor shift by 16 and keep 32 bits; special cases
   // bypass the arithmetic.
   logic               rsp_valid_ff;
   logic [DW-1:0]      rsp_value_out_ff, rsp_value_out_in;
   logic [DW+15:0]     prod_wide;
   logic [DW+15:0]     prod_neg;

   always_comb begin
      prod_wide = (DW+16)'(m_prod_ff);
      prod_neg  = (DW+16)'(0) - prod_wide;
      if (m_side_ff.special) begin
         rsp_value_out_in = m_side_ff.special_val;
      end else if (m_side_ff.neg) begin
         rsp_value_out_in = prod_neg[DW+15:16];
      end else begin
         rsp_value_out_in = prod_wide[DW+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_out_ff <= rsp_value_out_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = $signed(rsp_value_out_ff);

   // ---------------------------------------------------------------- checks
   // An accepted beat enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> a_valid_ff)
      else $error("accepted beat did not enter the pipeline");

   // The sigmoid quotient never exceeds 1.0 in Q16.
   a_sigmoid_range: assert property (@(posedge clock) disable iff (reset)
      dv_valid[QW] |-> (dv_div[QW].quo <= QW'(17'h10000)))
      else $error("sigmoid quotient above one");

   // For positive x the result never exceeds x.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff && !m_side_ff.special && !m_side_ff.neg)
         |-> (m_prod_ff[PW-1:16] <= (PW-16)'(m_side_ff.mag)))
      else $error("positive result above input");

endmodule

`default_nettype wire
